// ===== src/tpi_pkg.sv =====
// ============================================================================
// tpi_pkg
// Shared types, constants and tables of the turtle path interpreter.
// ============================================================================
package tpi_pkg;

    localparam int ANGLE_BITS_DEF = 16;
    localparam int FRAC_BITS_DEF  = 16;
    localparam int INDEX_BITS_DEF = 20;

    localparam int SYM_W       = 8;
    localparam int IDX_OUT_W   = 20;
    localparam int POS_W       = 32;
    localparam int CFG_ANGLE_W = 16;
    localparam int MASK_W      = 256;

    localparam int APB_ADDR_W = 6;
    localparam int APB_DATA_W = 64;

    localparam int QUEUE_DEPTH = 4;

    localparam int CORDIC_STEPS = 24;
    localparam int CORDIC_Q     = 30;
    localparam int CORDIC_W     = 34;
    localparam logic signed [CORDIC_W-1:0] CORDIC_GAIN = 34'sd652032874;

    localparam logic [SYM_W-1:0] SYM_PLUS  = 8'h2B;
    localparam logic [SYM_W-1:0] SYM_MINUS = 8'h2D;

    typedef enum logic [2:0] {
        REG_DRAW_MASK_0 = 3'd0,
        REG_DRAW_MASK_1 = 3'd1,
        REG_DRAW_MASK_2 = 3'd2,
        REG_DRAW_MASK_3 = 3'd3,
        REG_START_ANGLE = 3'd4,
        REG_TURN_ANGLE  = 3'd5
    } reg_idx_t;

    typedef struct packed {
        logic restart;
        logic draw;
    } cmd_flags_t;

    function automatic logic [31:0] atan_val(input int unsigned k);
        logic [31:0] v;
        case (k)
            0:       v = 32'h20000000;
            1:       v = 32'h12E4051E;
            2:       v = 32'h09FB385B;
            3:       v = 32'h051111D4;
            4:       v = 32'h028B0D43;
            5:       v = 32'h0145D7E1;
            6:       v = 32'h00A2F61E;
            7:       v = 32'h00517C55;
            8:       v = 32'h0028BE53;
            9:       v = 32'h00145F2F;
            10:      v = 32'h000A2F98;
            11:      v = 32'h000517CC;
            12:      v = 32'h00028BE6;
            13:      v = 32'h000145F3;
            14:      v = 32'h0000A2FA;
            15:      v = 32'h0000517D;
            16:      v = 32'h000028BE;
            17:      v = 32'h0000145F;
            18:      v = 32'h00000A30;
            19:      v = 32'h00000518;
            20:      v = 32'h0000028C;
            21:      v = 32'h00000146;
            22:      v = 32'h000000A3;
            23:      v = 32'h00000051;
            default: v = 32'h00000000;
        endcase
        return v;
    endfunction

endpackage

// ===== src/tpi_regs.sv =====
// ============================================================================
// tpi_regs
// APB register file: drawing mask, start angle and turn angle.
// ============================================================================
module tpi_regs (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [tpi_pkg::APB_ADDR_W-1:0]  paddr,
    input  logic [tpi_pkg::APB_DATA_W-1:0]  pwdata,
    output logic [tpi_pkg::APB_DATA_W-1:0]  prdata,
    output logic                            pready,
    output logic [tpi_pkg::MASK_W-1:0]      draw_mask,
    output logic [tpi_pkg::CFG_ANGLE_W-1:0] start_angle,
    output logic [tpi_pkg::CFG_ANGLE_W-1:0] turn_angle
);

    logic [tpi_pkg::APB_DATA_W-1:0]  mask_reg [0:3];
    logic [tpi_pkg::CFG_ANGLE_W-1:0] start_reg;
    logic [tpi_pkg::CFG_ANGLE_W-1:0] turn_reg;
    tpi_pkg::reg_idx_t               idx;
    logic                            wr_en;

    assign pready = 1'b1;
    assign idx    = tpi_pkg::reg_idx_t'(paddr[5:3]);
    assign wr_en  = psel & penable & pwrite & pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mask_reg[0] <= '0;
            mask_reg[1] <= '0;
            mask_reg[2] <= '0;
            mask_reg[3] <= '0;
            start_reg   <= '0;
            turn_reg    <= '0;
        end
        else if (wr_en)
        begin
            case (idx)
                tpi_pkg::REG_DRAW_MASK_0: mask_reg[0] <= pwdata;
                tpi_pkg::REG_DRAW_MASK_1: mask_reg[1] <= pwdata;
                tpi_pkg::REG_DRAW_MASK_2: mask_reg[2] <= pwdata;
                tpi_pkg::REG_DRAW_MASK_3: mask_reg[3] <= pwdata;
                tpi_pkg::REG_START_ANGLE: start_reg   <= pwdata[15:0];
                tpi_pkg::REG_TURN_ANGLE:  turn_reg    <= pwdata[15:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        case (idx)
            tpi_pkg::REG_DRAW_MASK_0: prdata = mask_reg[0];
            tpi_pkg::REG_DRAW_MASK_1: prdata = mask_reg[1];
            tpi_pkg::REG_DRAW_MASK_2: prdata = mask_reg[2];
            tpi_pkg::REG_DRAW_MASK_3: prdata = mask_reg[3];
            tpi_pkg::REG_START_ANGLE: prdata = {48'd0, start_reg};
            tpi_pkg::REG_TURN_ANGLE:  prdata = {48'd0, turn_reg};
            default:                  prdata = '0;
        endcase
    end

    assign draw_mask   = {mask_reg[3], mask_reg[2], mask_reg[1], mask_reg[0]};
    assign start_angle = start_reg;
    assign turn_angle  = turn_reg;

endmodule

// ===== src/tpi_front.sv =====
// ============================================================================
// tpi_front
// Symbol decoder: tracks the heading, folds turns in, queues move commands.
// ============================================================================
module tpi_front #(
    parameter int ANGLE_BITS = tpi_pkg::ANGLE_BITS_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            in_valid,
    output logic                            in_ready,
    input  logic [tpi_pkg::SYM_W-1:0]       symbol,
    input  logic                            new_drawing,
    input  logic [tpi_pkg::MASK_W-1:0]      draw_mask,
    input  logic [tpi_pkg::CFG_ANGLE_W-1:0] start_angle,
    input  logic [tpi_pkg::CFG_ANGLE_W-1:0] turn_angle,
    input  logic                            q_ready,
    output logic                            q_push,
    output logic [ANGLE_BITS-1:0]           q_heading,
    output tpi_pkg::cmd_flags_t             q_flags
);

    logic [ANGLE_BITS-1:0] heading_reg, heading_next;
    logic                  pend_reg, pend_next;
    logic [ANGLE_BITS-1:0] base_heading;
    logic [ANGLE_BITS-1:0] turn_a;
    logic                  restart;
    logic                  accept;

    assign in_ready = q_ready;
    assign accept   = in_valid & in_ready;
    assign turn_a   = ANGLE_BITS'(turn_angle);

    always_comb
    begin
        base_heading = new_drawing ? ANGLE_BITS'(start_angle) : heading_reg;
        restart      = new_drawing | pend_reg;
        heading_next = heading_reg;
        pend_next    = pend_reg;
        q_push       = 1'b0;
        if (accept)
        begin
            if (symbol == tpi_pkg::SYM_PLUS)
            begin
                heading_next = base_heading + turn_a;
                pend_next    = restart;
            end
            else if (symbol == tpi_pkg::SYM_MINUS)
            begin
                heading_next = base_heading - turn_a;
                pend_next    = restart;
            end
            else
            begin
                heading_next = base_heading;
                pend_next    = 1'b0;
                q_push       = 1'b1;
            end
        end
    end

    assign q_heading       = base_heading;
    assign q_flags.restart = restart;
    assign q_flags.draw    = draw_mask[symbol];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            heading_reg <= '0;
            pend_reg    <= 1'b0;
        end
        else
        begin
            heading_reg <= heading_next;
            pend_reg    <= pend_next;
        end
    end

endmodule

// ===== src/tpi_queue.sv =====
// ============================================================================
// tpi_queue
// Small register FIFO between the decoder and the path engine.
// ============================================================================
module tpi_queue #(
    parameter int WIDTH = 8,
    parameter int DEPTH = tpi_pkg::QUEUE_DEPTH
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic [WIDTH-1:0] push_data,
    output logic             push_ready,
    input  logic             pop,
    output logic             pop_valid,
    output logic [WIDTH-1:0] pop_data
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] mem_reg [0:DEPTH-1];
    logic [PTR_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [CNT_W-1:0] count_reg;
    logic             do_push, do_pop;

    assign push_ready = (count_reg != CNT_W'(DEPTH));
    assign pop_valid  = (count_reg != '0);
    assign pop_data   = mem_reg[rd_ptr_reg];
    assign do_push    = push & push_ready;
    assign do_pop     = pop & pop_valid;

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (do_pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (do_push && !do_pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (do_pop && !do_push)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

endmodule

// ===== src/tpi_cordic.sv =====
// ============================================================================
// tpi_cordic
// Pipelined rotation-mode CORDIC: one step per stage, cos and sin rounded.
// ============================================================================
module tpi_cordic #(
    parameter int ANGLE_BITS = tpi_pkg::ANGLE_BITS_DEF,
    parameter int FRAC_BITS  = tpi_pkg::FRAC_BITS_DEF
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        en,
    input  logic                        in_valid,
    input  logic [ANGLE_BITS-1:0]       in_angle,
    input  tpi_pkg::cmd_flags_t         in_flags,
    output logic                        out_valid,
    output logic signed [FRAC_BITS+1:0] out_cos,
    output logic signed [FRAC_BITS+1:0] out_sin,
    output tpi_pkg::cmd_flags_t         out_flags
);

    localparam int CW    = tpi_pkg::CORDIC_W;
    localparam int STEPS = tpi_pkg::CORDIC_STEPS;
    localparam int RS    = tpi_pkg::CORDIC_Q - FRAC_BITS;
    localparam int DW    = FRAC_BITS + 2;
    localparam logic signed [CW-1:0] QUARTER = 34'sd1073741824;
    localparam logic signed [CW-1:0] HALF_TURN = 34'sd2147483648;
    localparam logic signed [CW-1:0] RND = CW'(64'd1 << (RS - 1));

    logic signed [CW-1:0] x_reg [0:STEPS];
    logic signed [CW-1:0] y_reg [0:STEPS];
    logic signed [CW-1:0] z_reg [0:STEPS];
    logic                 neg_reg [0:STEPS];
    tpi_pkg::cmd_flags_t  flags_reg [0:STEPS];
    logic [STEPS:0]       valid_reg;

    logic signed [CW-1:0] x_next [0:STEPS-1];
    logic signed [CW-1:0] y_next [0:STEPS-1];
    logic signed [CW-1:0] z_next [0:STEPS-1];

    logic signed [31:0]   a32;
    logic signed [CW-1:0] z_in, z_fold;
    logic                 neg_fold;
    logic signed [CW-1:0] x_fin, y_fin, x_rnd, y_rnd;

    logic                 rv_reg;
    logic signed [DW-1:0] rc_reg, rs_reg;
    tpi_pkg::cmd_flags_t  rf_reg;

    always_comb
    begin
        a32  = {in_angle, {(32 - ANGLE_BITS){1'b0}}};
        z_in = CW'(a32);
        if (z_in > QUARTER)
        begin
            z_fold   = z_in - HALF_TURN;
            neg_fold = 1'b1;
        end
        else if (z_in < -QUARTER)
        begin
            z_fold   = z_in + HALF_TURN;
            neg_fold = 1'b1;
        end
        else
        begin
            z_fold   = z_in;
            neg_fold = 1'b0;
        end
    end

    always_comb
    begin
        for (int k = 0; k < STEPS; k++)
        begin
            if (!z_reg[k][CW-1])
            begin
                x_next[k] = x_reg[k] - (y_reg[k] >>> k);
                y_next[k] = y_reg[k] + (x_reg[k] >>> k);
                z_next[k] = z_reg[k] - CW'(tpi_pkg::atan_val(k));
            end
            else
            begin
                x_next[k] = x_reg[k] + (y_reg[k] >>> k);
                y_next[k] = y_reg[k] - (x_reg[k] >>> k);
                z_next[k] = z_reg[k] + CW'(tpi_pkg::atan_val(k));
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            x_reg[0]     <= tpi_pkg::CORDIC_GAIN;
            y_reg[0]     <= '0;
            z_reg[0]     <= z_fold;
            neg_reg[0]   <= neg_fold;
            flags_reg[0] <= in_flags;
            for (int k = 0; k < STEPS; k++)
            begin
                x_reg[k+1]     <= x_next[k];
                y_reg[k+1]     <= y_next[k];
                z_reg[k+1]     <= z_next[k];
                neg_reg[k+1]   <= neg_reg[k];
                flags_reg[k+1] <= flags_reg[k];
            end
        end
    end

    always_comb
    begin
        x_fin = neg_reg[STEPS] ? -x_reg[STEPS] : x_reg[STEPS];
        y_fin = neg_reg[STEPS] ? -y_reg[STEPS] : y_reg[STEPS];
        x_rnd = (x_fin + RND) >>> RS;
        y_rnd = (y_fin + RND) >>> RS;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rc_reg <= x_rnd[DW-1:0];
            rs_reg <= y_rnd[DW-1:0];
            rf_reg <= flags_reg[STEPS];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
            rv_reg    <= 1'b0;
        end
        else if (en)
        begin
            valid_reg <= {valid_reg[STEPS-1:0], in_valid};
            rv_reg    <= valid_reg[STEPS];
        end
    end

    assign out_valid = rv_reg;
    assign out_cos   = rc_reg;
    assign out_sin   = rs_reg;
    assign out_flags = rf_reg;

endmodule

// ===== src/tpi_back.sv =====
// ============================================================================
// tpi_back
// Path engine: unit step through the CORDIC, saturating position update,
// point counter and output register.
// ============================================================================
module tpi_back #(
    parameter int ANGLE_BITS = tpi_pkg::ANGLE_BITS_DEF,
    parameter int FRAC_BITS  = tpi_pkg::FRAC_BITS_DEF,
    parameter int INDEX_BITS = tpi_pkg::INDEX_BITS_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              q_valid,
    input  logic [ANGLE_BITS-1:0]             q_heading,
    input  tpi_pkg::cmd_flags_t               q_flags,
    output logic                              q_pop,
    output logic                              out_valid,
    input  logic                              out_ready,
    output logic [tpi_pkg::IDX_OUT_W-1:0]     point_index,
    output logic signed [tpi_pkg::POS_W-1:0]  pos_x,
    output logic signed [tpi_pkg::POS_W-1:0]  pos_y,
    output logic                              draws_line,
    output logic                              overflow
);

    localparam int PW    = tpi_pkg::POS_W;
    localparam int SW    = PW + 2;
    localparam int DW    = FRAC_BITS + 2;
    localparam int IdxOutW = tpi_pkg::IDX_OUT_W;
    localparam logic signed [SW-1:0] POS_MAX = 34'sd2147483647;
    localparam logic signed [SW-1:0] POS_MIN = -34'sd2147483648;

    logic                 en;
    logic                 st_valid;
    logic signed [DW-1:0] st_cos, st_sin;
    tpi_pkg::cmd_flags_t  st_flags;

    logic signed [PW-1:0]   cur_x_reg, cur_x_next;
    logic signed [PW-1:0]   cur_y_reg, cur_y_next;
    logic [INDEX_BITS-1:0]  count_reg, count_next;
    logic                   valid_reg;
    logic [IdxOutW-1:0]     index_reg;
    logic                   draw_reg, ovf_reg;

    logic signed [PW-1:0]   base_x, base_y;
    logic [INDEX_BITS-1:0]  base_cnt;
    logic signed [SW-1:0]   sum_x, sum_y;
    logic                   ovf;

    assign en    = !valid_reg | out_ready;
    assign q_pop = q_valid & en;

    tpi_cordic #(
        .ANGLE_BITS (ANGLE_BITS),
        .FRAC_BITS  (FRAC_BITS)
    ) u_cordic (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (q_valid),
        .in_angle  (q_heading),
        .in_flags  (q_flags),
        .out_valid (st_valid),
        .out_cos   (st_cos),
        .out_sin   (st_sin),
        .out_flags (st_flags)
    );

    always_comb
    begin
        base_x   = st_flags.restart ? '0 : cur_x_reg;
        base_y   = st_flags.restart ? '0 : cur_y_reg;
        base_cnt = st_flags.restart ? '0 : count_reg;
        sum_x    = SW'(base_x) + SW'(st_cos);
        sum_y    = SW'(base_y) + SW'(st_sin);
        ovf      = 1'b0;
        if (sum_x > POS_MAX)
        begin
            cur_x_next = PW'(POS_MAX);
            ovf        = 1'b1;
        end
        else if (sum_x < POS_MIN)
        begin
            cur_x_next = PW'(POS_MIN);
            ovf        = 1'b1;
        end
        else
        begin
            cur_x_next = sum_x[PW-1:0];
        end
        if (sum_y > POS_MAX)
        begin
            cur_y_next = PW'(POS_MAX);
            ovf        = 1'b1;
        end
        else if (sum_y < POS_MIN)
        begin
            cur_y_next = PW'(POS_MIN);
            ovf        = 1'b1;
        end
        else
        begin
            cur_y_next = sum_y[PW-1:0];
        end
        if (base_cnt == '1)
        begin
            count_next = base_cnt;
            ovf        = 1'b1;
        end
        else
        begin
            count_next = base_cnt + 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            cur_x_reg <= '0;
            cur_y_reg <= '0;
            count_reg <= '0;
        end
        else if (en)
        begin
            valid_reg <= st_valid;
            if (st_valid)
            begin
                cur_x_reg <= cur_x_next;
                cur_y_reg <= cur_y_next;
                count_reg <= count_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en && st_valid)
        begin
            index_reg <= IdxOutW'(count_next);
            draw_reg  <= st_flags.draw;
            ovf_reg   <= ovf;
        end
    end

    assign out_valid   = valid_reg;
    assign point_index = index_reg;
    assign pos_x       = cur_x_reg;
    assign pos_y       = cur_y_reg;
    assign draws_line  = draw_reg;
    assign overflow    = ovf_reg;

endmodule

// ===== src/turtle_path_interpreter_top.sv =====
// ============================================================================
// turtle_path_interpreter_top
// Turtle path interpreter over an expanded symbol stream, with APB setup.
// ============================================================================
// Throughput: one symbol per cycle while s_tready is high; turn symbols give no word.
// A move symbol passes the queue, the CORDIC pipeline and the position register.
// Reset clears heading, position, point count, queue and registers to zero.
module turtle_path_interpreter_top #(
    parameter int ANGLE_BITS = tpi_pkg::ANGLE_BITS_DEF,
    parameter int FRAC_BITS  = tpi_pkg::FRAC_BITS_DEF,
    parameter int INDEX_BITS = tpi_pkg::INDEX_BITS_DEF
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    input  logic [7:0]                     s_tdata,   // symbol
    input  logic [0:0]                     s_tuser,   // new_drawing
    output logic                           m_tvalid,
    input  logic                           m_tready,
    output logic [87:0]                    m_tdata,   // point_index, pos_x, pos_y, pad
    output logic [1:0]                     m_tuser,   // draws_line, overflow
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [tpi_pkg::APB_ADDR_W-1:0] paddr,
    input  logic [tpi_pkg::APB_DATA_W-1:0] pwdata,
    output logic [tpi_pkg::APB_DATA_W-1:0] prdata,
    output logic                           pready
);

    localparam int QW = ANGLE_BITS + 2;

    logic [tpi_pkg::MASK_W-1:0]      draw_mask;
    logic [tpi_pkg::CFG_ANGLE_W-1:0] start_angle;
    logic [tpi_pkg::CFG_ANGLE_W-1:0] turn_angle;

    logic                  f_push;
    logic [ANGLE_BITS-1:0] f_heading;
    tpi_pkg::cmd_flags_t   f_flags;
    logic                  q_ready;
    logic                  q_valid;
    logic                  q_pop;
    logic [QW-1:0]         q_data;
    tpi_pkg::cmd_flags_t   q_flags;

    logic [tpi_pkg::IDX_OUT_W-1:0]    point_index;
    logic signed [tpi_pkg::POS_W-1:0] pos_x, pos_y;
    logic                             draws_line, overflow;

    tpi_regs u_regs (
        .clk         (clk),
        .rst_n       (rst_n),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready),
        .draw_mask   (draw_mask),
        .start_angle (start_angle),
        .turn_angle  (turn_angle)
    );

    tpi_front #(
        .ANGLE_BITS (ANGLE_BITS)
    ) u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (s_tvalid),
        .in_ready    (s_tready),
        .symbol      (s_tdata),
        .new_drawing (s_tuser[0]),
        .draw_mask   (draw_mask),
        .start_angle (start_angle),
        .turn_angle  (turn_angle),
        .q_ready     (q_ready),
        .q_push      (f_push),
        .q_heading   (f_heading),
        .q_flags     (f_flags)
    );

    tpi_queue #(
        .WIDTH (QW),
        .DEPTH (tpi_pkg::QUEUE_DEPTH)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (f_push),
        .push_data  ({f_flags, f_heading}),
        .push_ready (q_ready),
        .pop        (q_pop),
        .pop_valid  (q_valid),
        .pop_data   (q_data)
    );

    assign q_flags = tpi_pkg::cmd_flags_t'(q_data[QW-1:ANGLE_BITS]);

    tpi_back #(
        .ANGLE_BITS (ANGLE_BITS),
        .FRAC_BITS  (FRAC_BITS),
        .INDEX_BITS (INDEX_BITS)
    ) u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .q_valid     (q_valid),
        .q_heading   (q_data[ANGLE_BITS-1:0]),
        .q_flags     (q_flags),
        .q_pop       (q_pop),
        .out_valid   (m_tvalid),
        .out_ready   (m_tready),
        .point_index (point_index),
        .pos_x       (pos_x),
        .pos_y       (pos_y),
        .draws_line  (draws_line),
        .overflow    (overflow)
    );

    assign m_tdata = {4'd0, pos_y, pos_x, point_index};
    assign m_tuser = {overflow, draws_line};

endmodule
